// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by rational_arithmetic_unit.sv.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An expression that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int NUM_BITS = 33;
  localparam int DEN_BITS = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

endpackage

// ----- hw/rtl/rau_if.sv -----
`timescale 1ns / 1ps
// Request channel: operation code and two signed fractions.
interface rau_req_if #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic signed [OPERAND_BITS-1:0] a_num;
  logic signed [OPERAND_BITS-1:0] a_den;
  logic signed [OPERAND_BITS-1:0] b_num;
  logic signed [OPERAND_BITS-1:0] b_den;

  modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

// Response channel: reduced fraction and flags.
interface rau_rsp_if;
  import rau_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [NUM_BITS-1:0] result_num;
  logic [DEN_BITS-1:0]        result_den;
  logic                       is_whole;
  logic [1:0]                 status;

  modport source (output valid, result_num, result_den, is_whole, status, input ready);
  modport sink (input valid, result_num, result_den, is_whole, status, output ready);
endinterface

// ----- hw/rtl/rau_mul.sv -----
`timescale 1ns / 1ps
// Sign-magnitude multiplier with a registered product.
module rau_mul #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
  input  logic                      clk,
  input  logic [OPERAND_BITS-1:0]   x_mag,
  input  logic                      x_neg,
  input  logic [OPERAND_BITS-1:0]   y_mag,
  input  logic                      y_neg,
  output logic [2*OPERAND_BITS-1:0] p_mag,
  output logic                      p_neg
);
  import rau_pkg::*;

  // A zero product never carries a sign.
  always_ff @(posedge clk) begin
    p_mag <= (2*OPERAND_BITS)'(x_mag) * (2*OPERAND_BITS)'(y_mag);
    p_neg <= (x_neg ^ y_neg) && (x_mag != '0) && (y_mag != '0);
  end

endmodule

// ----- hw/rtl/rau_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module rau_div #(
  parameter int WIDTH = 2 * rau_pkg::OPERAND_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  assign shifted = {rem, quot[WIDTH-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[WIDTH-2:0], ge};
      rem  <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
//  Channel | Dir | Payload                                        | Transfer when
//  req     | in  | operation, a_num, a_den, b_num, b_den          | req.valid & req.ready
//  rsp     | out | result_num, result_den, is_whole, status       | rsp.valid & rsp.ready
//
// One item at a time: the request transfers, the shared multiplier forms the
// partial products and the adder their sum, then the shared divider (W = 2 *
// OPERAND_BITS) runs one division per Euclid step and then the two final quotients,
// and the output register is loaded. Zero results and flagged items skip ahead.
// Reset is synchronous and active high; it clears the sequencer and rsp.valid.
// A stalled result sits in the output register while the next item is taken.
`include "assert_macros.svh"

module rational_arithmetic_unit #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);
  import rau_pkg::*;

  // Full product width: magnitudes reach 2^(2B-2), their sum 2^(2B-1).
  localparam int W  = 2 * OPERAND_BITS;
  localparam int NW = (W > NUM_BITS) ? W : NUM_BITS;
  localparam int DW = (W > DEN_BITS) ? W : DEN_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_GCD  = 7'b0001000,
    S_QN   = 7'b0010000,
    S_QD   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  op_t    op;
  logic   [1:0] cnt;
  logic   issued;

  // Operand magnitudes and signs, captured when the request transfers.
  logic [OPERAND_BITS-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic                    an_neg, ad_neg, bn_neg, bd_neg;
  logic [OPERAND_BITS-1:0] an_raw, ad_raw, bn_raw, bd_raw;

  // Partial products, raw numerator/denominator, and the Euclid pair.
  logic [W-1:0] t0_mag, t1_mag, nmag, dmag, ga, gb;
  logic         t0_neg, t1_neg, nneg, dneg;
  status_t      status;

  // Shared multiplier.
  logic [OPERAND_BITS-1:0] mx_mag, my_mag;
  logic                    mx_neg, my_neg;
  logic [W-1:0]            p_mag;
  logic                    p_neg;

  // Shared divider.
  logic         div_start, div_done;
  logic [W-1:0] div_dividend, div_divisor, div_quot, div_rem;

  // Adder for add and subtract.
  logic         tb_neg;
  logic [W-1:0] sum_mag;
  logic         sum_neg;

  // Output formatting.
  logic          load_out;
  logic [NW-1:0] nm_ext, num_signed;
  logic [DW-1:0] dm_ext;

  // Terms used by the checks at the end.
  logic rsp_flagged, rsp_zero_frac, div_phase;

  assign an_raw = req.a_num;
  assign ad_raw = req.a_den;
  assign bn_raw = req.b_num;
  assign bd_raw = req.b_den;

  assign req.ready = (state == S_IDLE);

  // Operand pairs: step 0 gives the first numerator product, step 1 the
  // cross term for add and subtract, step 2 the denominator product.
  always_comb begin
    case (cnt)
      2'd0: begin
        mx_mag = an_mag;
        mx_neg = an_neg;
        my_mag = (op == OP_MUL) ? bn_mag : bd_mag;
        my_neg = (op == OP_MUL) ? bn_neg : bd_neg;
      end
      2'd1: begin
        mx_mag = bn_mag;
        mx_neg = bn_neg;
        my_mag = ad_mag;
        my_neg = ad_neg;
      end
      default: begin
        mx_mag = ad_mag;
        mx_neg = ad_neg;
        my_mag = (op == OP_DIV) ? bn_mag : bd_mag;
        my_neg = (op == OP_DIV) ? bn_neg : bd_neg;
      end
    endcase
  end

  rau_mul #(.OPERAND_BITS(OPERAND_BITS)) u_mul (
    .clk   (clk),
    .x_mag (mx_mag),
    .x_neg (mx_neg),
    .y_mag (my_mag),
    .y_neg (my_neg),
    .p_mag (p_mag),
    .p_neg (p_neg)
  );

  // Signed-magnitude add; subtract flips the cross term's sign; mul/div pass t0.
  always_comb begin
    tb_neg = t1_neg ^ ((op == OP_SUB) && (t1_mag != '0));
    if (!(op inside {OP_ADD, OP_SUB})) begin
      sum_mag = t0_mag;
      sum_neg = t0_neg;
    end else if (t0_neg == tb_neg) begin
      sum_mag = t0_mag + t1_mag;
      sum_neg = t0_neg;
    end else if (t0_mag >= t1_mag) begin
      sum_mag = t0_mag - t1_mag;
      sum_neg = t0_neg;
    end else begin
      sum_mag = t1_mag - t0_mag;
      sum_neg = tb_neg;
    end
  end

  // The divider serves the Euclid remainders and both final quotients.
  assign div_start = !issued &&
                     (((state == S_GCD) && (gb != '0)) || (state == S_QN) || (state == S_QD));
  assign div_dividend = (state == S_GCD) ? ga : ((state == S_QN) ? nmag : dmag);
  assign div_divisor  = (state == S_GCD) ? gb : ga;

  rau_div #(.WIDTH(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      issued <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cnt    <= '0;
            issued <= 1'b0;
            if ((ad_raw == '0) || (bd_raw == '0) ||
                ((op_t'(req.operation) == OP_DIV) && (bn_raw == '0))) begin
              state <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= (sum_mag == '0) ? S_OUT : S_GCD;
        end
        S_GCD: begin
          if (!issued) begin
            if (gb == '0) begin
              state <= S_QN;
            end else begin
              issued <= 1'b1;
            end
          end else if (div_done) begin
            issued <= 1'b0;
          end
        end
        S_QN: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (div_done) begin
            issued <= 1'b0;
            state  <= S_QD;
          end
        end
        S_QD: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (div_done) begin
            issued <= 1'b0;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op     <= op_t'(req.operation);
        an_neg <= an_raw[OPERAND_BITS-1];
        ad_neg <= ad_raw[OPERAND_BITS-1];
        bn_neg <= bn_raw[OPERAND_BITS-1];
        bd_neg <= bd_raw[OPERAND_BITS-1];
        an_mag <= an_raw[OPERAND_BITS-1] ? (~an_raw + 1'b1) : an_raw;
        ad_mag <= ad_raw[OPERAND_BITS-1] ? (~ad_raw + 1'b1) : ad_raw;
        bn_mag <= bn_raw[OPERAND_BITS-1] ? (~bn_raw + 1'b1) : bn_raw;
        bd_mag <= bd_raw[OPERAND_BITS-1] ? (~bd_raw + 1'b1) : bd_raw;
        // Flagged items leave as 0/1 with their status.
        nmag   <= '0;
        dmag   <= W'(1);
        nneg   <= 1'b0;
        dneg   <= 1'b0;
        if ((ad_raw == '0) || (bd_raw == '0)) begin
          status <= ST_ZERO_DEN;
        end else if ((op_t'(req.operation) == OP_DIV) && (bn_raw == '0)) begin
          status <= ST_DIV_ZERO;
        end else begin
          status <= ST_OK;
        end
      end
      S_MUL: begin
        case (cnt)
          2'd1: begin
            t0_mag <= p_mag;
            t0_neg <= p_neg;
          end
          2'd2: begin
            t1_mag <= p_mag;
            t1_neg <= p_neg;
          end
          2'd3: begin
            dmag <= p_mag;
            dneg <= p_neg;
          end
          default: begin
          end
        endcase
      end
      S_SUM: begin
        if (sum_mag == '0) begin
          // Zero result is 0/1 with no sign.
          nmag <= '0;
          nneg <= 1'b0;
          dmag <= W'(1);
          dneg <= 1'b0;
        end else begin
          nmag <= sum_mag;
          nneg <= sum_neg;
          ga   <= sum_mag;
          gb   <= dmag;
        end
      end
      S_GCD: begin
        if (issued && div_done) begin
          ga <= gb;
          gb <= div_rem;
        end
      end
      S_QN: begin
        if (issued && div_done) begin
          nmag <= div_quot;
        end
      end
      S_QD: begin
        if (issued && div_done) begin
          dmag <= div_quot;
        end
      end
      default: begin
      end
    endcase
  end

  // The output register frees the sequencer while a result waits.
  assign load_out   = (state == S_OUT) && (!rsp.valid || rsp.ready);
  assign nm_ext     = NW'(nmag);
  assign num_signed = (nneg ^ dneg) ? (~nm_ext + 1'b1) : nm_ext;
  assign dm_ext     = DW'(dmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.result_num <= num_signed[NUM_BITS-1:0];
      rsp.result_den <= dm_ext[DEN_BITS-1:0];
      rsp.is_whole   <= (dmag == W'(1)) && (status == ST_OK);
      rsp.status     <= status;
    end
  end

  assign rsp_flagged   = rsp.valid && (rsp.status != ST_OK);
  assign rsp_zero_frac = (rsp.result_num == '0) && (rsp.result_den == DEN_BITS'(1)) &&
                         !rsp.is_whole;
  assign div_phase     = issued && ((state == S_GCD) || (state == S_QN) || (state == S_QD));

  // A flagged result is always 0/1 and never whole.
  `ASSERT_IMPLIES(a_flag_zero, rsp_flagged, rsp_zero_frac, "flagged result is not 0/1")
  // The divider is never started on a zero divisor.
  `ASSERT_IMPLIES(a_div_nonzero, div_start, div_divisor != '0, "divider started with zero divisor")
  // A divider completion only arrives for a division the sequencer issued.
  `ASSERT_IMPLIES(a_div_done_issued, div_done, div_phase, "unexpected divider completion")

endmodule
